// File: hw/rtl/mbpe_pkg.sv
package mbpe_pkg;

  // Size limits of the bitmap and of the frame.
  localparam logic [6:0]  MAX_BITMAP_WIDTH  = 7'd64;
  localparam logic [6:0]  MAX_BITMAP_HEIGHT = 7'd64;
  localparam logic [12:0] MAX_RESOLUTION    = 13'd4096;

  // Depth of the job queue between the front and the back.
  localparam int QUEUE_DEPTH = 2;
  localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
  localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

  // Width of the configuration register index.
  localparam int CFG_IDX_W = 3;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FRAME_WIDTH   = 3'd0,
    REG_FRAME_HEIGHT  = 3'd1,
    REG_PIXEL_FORMAT  = 3'd2,
    REG_VISIBLE_BASE  = 3'd3,
    REG_HIDDEN_BASE   = 3'd4,
    REG_TARGET_SELECT = 3'd5
  } mbpe_reg_t;

  // Pixel format codes.
  typedef enum logic [1:0] {
    PF_8BPP  = 2'd0,
    PF_16BPP = 2'd1,
    PF_24BPP = 2'd2,
    PF_32BPP = 2'd3
  } mbpe_pfmt_t;

  // Input transaction payload.
  typedef struct packed {
    logic        start_req;
    logic [11:0] origin_x;
    logic [11:0] origin_y;
    logic [6:0]  bitmap_width;
    logic [6:0]  bitmap_height;
    logic [23:0] color;
    logic [7:0]  bitmap_byte;
  } mbpe_in_t;

  // Result transaction payload.
  typedef struct packed {
    logic [31:0] write_address;
    logic [23:0] write_data;
    logic [1:0]  byte_count;
    logic        last;
  } mbpe_out_t;

  // Effective configuration, with the frame size already saturated.
  typedef struct packed {
    logic [12:0] frame_w;
    logic [12:0] frame_h;
    mbpe_pfmt_t  pfmt;
    logic [31:0] base;
    logic        bases_ok;
  } mbpe_cfg_t;

  // One byte's worth of drawing work; mask bit j is the pixel j columns right of x0.
  typedef struct packed {
    logic [12:0] x0;
    logic [11:0] y;
    logic [7:0]  mask;
    logic [23:0] color;
  } mbpe_job_t;

endpackage

// File: hw/rtl/mono_bitmap_pixel_expander.sv
// Channel   Direction  Payload     Handshake
// in_       input      mbpe_in_t   in_valid / in_ready
// out_      output     mbpe_out_t  out_valid / out_ready
// cfg_      input      32-bit reg  cfg_we, cfg_index (write only)
//
// The front takes one bitmap byte per cycle while the job queue has room.
// The back gives one pixel write per cycle while out_ready does not stall it, so a byte
// with n pixels to draw gives n writes (up to eight); bytes that draw nothing never enter the queue.
// A write passes the queue, the index stage, the address stage and the output register before it shows on out_valid.
// Reset is synchronous; registers take their reset values at a rising edge with rst_n low.
// A stalled result holds the back; the queue lets the front keep taking bytes until it fills.
module mono_bitmap_pixel_expander (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  mbpe_pkg::mbpe_in_t            in_data,
  output logic                          out_valid,
  input  logic                          out_ready,
  output mbpe_pkg::mbpe_out_t           out_data,
  input  logic                          cfg_we,
  input  logic [mbpe_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]                   cfg_wdata
);
  import mbpe_pkg::*;

  localparam logic [12:0] FRAME_W_RESET = 13'd640;
  localparam logic [12:0] FRAME_H_RESET = 13'd480;

  logic [12:0] frame_w_r;
  logic [12:0] frame_h_r;
  mbpe_pfmt_t  pfmt_r;
  logic [31:0] visible_base_r;
  logic [31:0] hidden_base_r;
  logic        target_sel_r;

  mbpe_cfg_t   cfg;
  logic        job_push;
  mbpe_job_t   job_in;
  logic        job_full;
  logic        job_pop;
  mbpe_job_t   job_out;
  logic        job_valid;

  // Configuration register writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_w_r      <= FRAME_W_RESET;
      frame_h_r      <= FRAME_H_RESET;
      pfmt_r         <= PF_32BPP;
      visible_base_r <= '0;
      hidden_base_r  <= '0;
      target_sel_r   <= 1'b1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_FRAME_WIDTH:   frame_w_r      <= cfg_wdata[12:0];
        REG_FRAME_HEIGHT:  frame_h_r      <= cfg_wdata[12:0];
        REG_PIXEL_FORMAT:  pfmt_r         <= mbpe_pfmt_t'(cfg_wdata[1:0]);
        REG_VISIBLE_BASE:  visible_base_r <= cfg_wdata;
        REG_HIDDEN_BASE:   hidden_base_r  <= cfg_wdata;
        REG_TARGET_SELECT: target_sel_r   <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // Effective configuration seen by both halves.
  always_comb begin
    cfg.frame_w  = (frame_w_r > MAX_RESOLUTION) ? MAX_RESOLUTION : frame_w_r;
    cfg.frame_h  = (frame_h_r > MAX_RESOLUTION) ? MAX_RESOLUTION : frame_h_r;
    cfg.pfmt     = pfmt_r;
    cfg.base     = target_sel_r ? visible_base_r : hidden_base_r;
    cfg.bases_ok = (visible_base_r != '0) && (hidden_base_r != '0);
  end

  mbpe_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .job_push (job_push),
    .job_data (job_in),
    .job_full (job_full)
  );

  mbpe_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (job_push),
    .push_data (job_in),
    .full      (job_full),
    .pop       (job_pop),
    .pop_data  (job_out),
    .not_empty (job_valid)
  );

  mbpe_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .job_valid (job_valid),
    .job_data  (job_out),
    .job_pop   (job_pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

// File: hw/rtl/mbpe_queue.sv
module mbpe_queue (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  mbpe_pkg::mbpe_job_t push_data,
  output logic               full,
  input  logic               pop,
  output mbpe_pkg::mbpe_job_t pop_data,
  output logic               not_empty
);
  import mbpe_pkg::*;

  mbpe_job_t              slot_r [QUEUE_DEPTH];
  logic [QUEUE_PTR_W-1:0] wr_ptr_r;
  logic [QUEUE_PTR_W-1:0] wr_ptr_nxt;
  logic [QUEUE_PTR_W-1:0] rd_ptr_r;
  logic [QUEUE_PTR_W-1:0] rd_ptr_nxt;
  logic [QUEUE_CNT_W-1:0] count_r;
  logic [QUEUE_CNT_W-1:0] count_nxt;

  assign full      = (count_r == QUEUE_CNT_W'(QUEUE_DEPTH));
  assign not_empty = (count_r != '0);
  assign pop_data  = slot_r[rd_ptr_r];

  // Pointer and fill count update; pointers wrap at the queue depth.
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Storage needs no reset.
  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

// File: hw/rtl/mbpe_front.sv
module mbpe_front (
  input  logic                clk,
  input  logic                rst_n,
  input  mbpe_pkg::mbpe_cfg_t cfg,
  input  logic                in_valid,
  output logic                in_ready,
  input  mbpe_pkg::mbpe_in_t  in_data,
  output logic                job_push,
  output mbpe_pkg::mbpe_job_t job_data,
  input  logic                job_full
);
  import mbpe_pkg::*;

  // Bitmap walk state.
  logic        active_r;
  logic        active_nxt;
  logic [11:0] start_x_r;
  logic [11:0] start_x_nxt;
  logic [12:0] row_y_r;
  logic [12:0] row_y_nxt;
  logic [3:0]  bytes_per_row_r;
  logic [3:0]  bytes_per_row_nxt;
  logic [6:0]  rows_left_r;
  logic [6:0]  rows_left_nxt;
  logic [3:0]  byte_column_r;
  logic [3:0]  byte_column_nxt;
  logic [23:0] color_r;
  logic [23:0] color_nxt;

  logic        take;
  logic [6:0]  w_eff;
  logic [6:0]  h_eff;
  logic [7:0]  w_round;
  logic        size_ok;
  logic        go;
  logic [11:0] cur_x;
  logic [12:0] cur_y;
  logic [3:0]  cur_bpr;
  logic [3:0]  cur_col;
  logic [6:0]  cur_rows;
  logic [23:0] cur_color;
  logic [12:0] x0;
  logic [12:0] px;
  logic [7:0]  mask;
  logic        draw_ok;
  logic [3:0]  col_inc;
  logic [6:0]  rows_dec;

  assign in_ready = !job_full;
  assign take     = in_valid && in_ready;

  // Classify the byte: pick the bitmap it belongs to and the pixels it draws.
  always_comb begin
    w_eff   = (in_data.bitmap_width > MAX_BITMAP_WIDTH) ? MAX_BITMAP_WIDTH
                                                        : in_data.bitmap_width;
    h_eff   = (in_data.bitmap_height > MAX_BITMAP_HEIGHT) ? MAX_BITMAP_HEIGHT
                                                          : in_data.bitmap_height;
    w_round = {1'b0, w_eff} + 8'd7;
    size_ok = (w_eff != '0) && (h_eff != '0);

    if (in_data.start_req) begin
      go        = size_ok;
      cur_x     = in_data.origin_x;
      cur_y     = {1'b0, in_data.origin_y};
      cur_bpr   = w_round[6:3];
      cur_col   = '0;
      cur_rows  = h_eff;
      cur_color = in_data.color;
    end else begin
      go        = active_r;
      cur_x     = start_x_r;
      cur_y     = row_y_r;
      cur_bpr   = bytes_per_row_r;
      cur_col   = byte_column_r;
      cur_rows  = rows_left_r;
      cur_color = color_r;
    end

    x0 = {1'b0, cur_x} + {6'b0, cur_col, 3'b000};
    for (int j = 0; j < 8; j++) begin
      px      = x0 + 13'(j);
      mask[j] = in_data.bitmap_byte[7 - j] && (px < cfg.frame_w);
    end
    draw_ok  = cfg.bases_ok && (cur_y < cfg.frame_h);
    job_push = take && go && draw_ok && (mask != '0);

    job_data.x0    = x0;
    job_data.y     = cur_y[11:0];
    job_data.mask  = mask;
    job_data.color = cur_color;
  end

  // Advance the bitmap position by one byte.
  always_comb begin
    active_nxt        = active_r;
    start_x_nxt       = start_x_r;
    row_y_nxt         = row_y_r;
    bytes_per_row_nxt = bytes_per_row_r;
    rows_left_nxt     = rows_left_r;
    byte_column_nxt   = byte_column_r;
    color_nxt         = color_r;
    col_inc           = cur_col + 1'b1;
    rows_dec          = cur_rows - 1'b1;
    if (take) begin
      if (in_data.start_req && !size_ok) begin
        active_nxt = 1'b0;
      end else if (go) begin
        start_x_nxt       = cur_x;
        bytes_per_row_nxt = cur_bpr;
        color_nxt         = cur_color;
        active_nxt        = 1'b1;
        if (col_inc >= cur_bpr) begin
          byte_column_nxt = '0;
          row_y_nxt       = cur_y + 1'b1;
          rows_left_nxt   = rows_dec;
          if (rows_dec == '0) begin
            active_nxt = 1'b0;
          end
        end else begin
          byte_column_nxt = col_inc;
          row_y_nxt       = cur_y;
          rows_left_nxt   = cur_rows;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r        <= 1'b0;
      start_x_r       <= '0;
      row_y_r         <= '0;
      bytes_per_row_r <= '0;
      rows_left_r     <= '0;
      byte_column_r   <= '0;
      color_r         <= '0;
    end else begin
      active_r        <= active_nxt;
      start_x_r       <= start_x_nxt;
      row_y_r         <= row_y_nxt;
      bytes_per_row_r <= bytes_per_row_nxt;
      rows_left_r     <= rows_left_nxt;
      byte_column_r   <= byte_column_nxt;
      color_r         <= color_nxt;
    end
  end

endmodule

// File: hw/rtl/mbpe_back.sv
module mbpe_back (
  input  logic                clk,
  input  logic                rst_n,
  input  mbpe_pkg::mbpe_cfg_t cfg,
  input  logic                job_valid,
  input  mbpe_pkg::mbpe_job_t job_data,
  output logic                job_pop,
  output logic                out_valid,
  input  logic                out_ready,
  output mbpe_pkg::mbpe_out_t out_data
);
  import mbpe_pkg::*;

  // Stage one: linear pixel index of the job's first column.
  logic        v1_r;
  logic [24:0] lin1_r;
  logic [7:0]  mask1_r;
  logic [23:0] color1_r;

  // Stage two: byte address of that column, emitting one pixel per cycle while the output register is free.
  logic        v2_r;
  logic        v2_nxt;
  logic [31:0] addr2_r;
  logic [7:0]  mask2_r;
  logic [7:0]  mask2_nxt;
  logic [23:0] data2_r;
  logic [1:0]  count2_r;

  // Output register.
  logic        out_v_r;
  logic        out_v_nxt;
  mbpe_out_t   out_r;

  logic        out_free;
  logic        emit;
  logic        done2;
  logic        load2;
  logic        load1;
  logic [24:0] lin_calc;
  logic [26:0] scaled;
  logic [31:0] addr_calc;
  logic [23:0] data_calc;
  logic [1:0]  count_calc;
  logic [2:0]  k;
  logic [4:0]  offset;
  logic [7:0]  rem;

  assign out_valid = out_v_r;
  assign out_data  = out_r;

  // Handshake between the stages.
  always_comb begin
    out_free = !out_v_r || out_ready;
    emit     = v2_r && out_free;
    rem      = mask2_r & (mask2_r - 8'd1);
    done2    = emit && (rem == '0);
    load2    = v1_r && (!v2_r || done2);
    load1    = job_valid && (!v1_r || load2);
    job_pop  = load1;
  end

  // Row index times stride, plus the starting column.
  assign lin_calc = ({13'b0, job_data.y} * {12'b0, cfg.frame_w}) + {12'b0, job_data.x0};

  // Scale the pixel index to bytes and pick the color bytes.
  always_comb begin
    unique case (cfg.pfmt)
      PF_8BPP: begin
        scaled     = {2'b0, lin1_r};
        data_calc  = {16'b0, color1_r[7:0]};
        count_calc = 2'd1;
      end
      PF_16BPP: begin
        scaled     = {1'b0, lin1_r, 1'b0};
        data_calc  = {8'b0, color1_r[15:0]};
        count_calc = 2'd2;
      end
      PF_24BPP: begin
        scaled     = {1'b0, lin1_r, 1'b0} + {2'b0, lin1_r};
        data_calc  = color1_r;
        count_calc = 2'd3;
      end
      default: begin
        scaled     = {lin1_r, 2'b0};
        data_calc  = color1_r;
        count_calc = 2'd3;
      end
    endcase
    addr_calc = cfg.base + {5'b0, scaled};
  end

  // Next pixel to draw: the leftmost remaining one.
  always_comb begin
    k = '0;
    for (int j = 7; j >= 0; j--) begin
      if (mask2_r[j]) begin
        k = 3'(j);
      end
    end
    unique case (cfg.pfmt)
      PF_8BPP:  offset = {2'b0, k};
      PF_16BPP: offset = {1'b0, k, 1'b0};
      PF_24BPP: offset = {1'b0, k, 1'b0} + {2'b0, k};
      default:  offset = {k, 2'b0};
    endcase
  end

  always_comb begin
    v2_nxt    = v2_r;
    mask2_nxt = mask2_r;
    if (emit) begin
      mask2_nxt = rem;
    end
    if (done2) begin
      v2_nxt = 1'b0;
    end
    if (load2) begin
      v2_nxt    = 1'b1;
      mask2_nxt = mask1_r;
    end
    out_v_nxt = out_v_r;
    if (out_ready) begin
      out_v_nxt = 1'b0;
    end
    if (emit) begin
      out_v_nxt = 1'b1;
    end
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r    <= 1'b0;
      v2_r    <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      if (load1) begin
        v1_r <= 1'b1;
      end else if (load2) begin
        v1_r <= 1'b0;
      end
      v2_r    <= v2_nxt;
      out_v_r <= out_v_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (load1) begin
      lin1_r   <= lin_calc;
      mask1_r  <= job_data.mask;
      color1_r <= job_data.color;
    end
    if (load2) begin
      addr2_r  <= addr_calc;
      data2_r  <= data_calc;
      count2_r <= count_calc;
    end
    mask2_r <= mask2_nxt;
    if (emit) begin
      out_r.write_address <= addr2_r + {27'b0, offset};
      out_r.write_data    <= data2_r;
      out_r.byte_count    <= count2_r;
      out_r.last          <= (rem == '0);
    end
  end

endmodule
